[hw/rtl/sorted_track_table_with_expiry_core_macros.svh]
// Assertion macros used by the core.
`ifndef SORTED_TRACK_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
`define SORTED_TRACK_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define STT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that an antecedent implies a consequent in the next cycle.
`define STT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/stte_pkg.sv]
package stte_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] ReqReport = 2'd0;
  localparam logic [1:0] ReqSweep  = 2'd1;
  localparam logic [1:0] ReqRead   = 2'd2;

  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StReadOk   = 3'd3;
  localparam logic [2:0] StBadIdx   = 3'd4;
  localparam logic [2:0] StSwept    = 3'd5;

  // One stored entry: 32+32+64+3+32+48+48 bits.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] frame;
    logic [63:0] box;
    logic [2:0]  kind;
    logic [31:0] quality;
    logic [47:0] ins_at;
    logic [47:0] ref_at;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_SWEEP, S_READ, S_DONE
  } state_t;
endpackage

[hw/rtl/stte_ram.sv]
// Entry storage with one write port and one registered read port.
module stte_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [stte_pkg::IdxW-1:0]         waddr,
  input  stte_pkg::entry_t                  wdata,
  input  logic [stte_pkg::IdxW-1:0]         raddr,
  output stte_pkg::entry_t                  rdata
);
  stte_pkg::entry_t mem [stte_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/sorted_track_table_with_expiry_core.sv]
// Sorted track table with expiry. Up to 16 entries are kept in ascending track
// number in a single-port-read entry memory, and one sequencer walks that memory
// for every transaction, so one item is handled at a time and in_tready is low
// while it works and while an earlier result still waits to be taken. A report
// binary-searches the key, each probe issuing an address and then taking the
// registered memory read, and an insert then moves every entry above the
// insertion point up by one. A sweep reads each valid entry once, compacting
// survivors down in place. The result sits in an output register until taken.
// in_tdata, low bit up: req_type, now_ms, track_key, frame_id, box_x, box_y,
// box_w, box_h, box_kind, quality_bits, read_slot (total 217 bits, padded to 224).
// out_tdata, low bit up: status, slot, entry_count, evicted_count, out_key,
// out_frame, out_x, out_y, out_w, out_h, out_kind, out_quality (total 180, pad 184).
// The memory has no reset; only entries below entry_count are ever shown in a result.
module sorted_track_table_with_expiry_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // fields as listed in the head comment
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata   // fields as listed in the head comment
);
  `include "sorted_track_table_with_expiry_core_macros.svh"

  localparam int IW = stte_pkg::IdxW;
  localparam int CW = stte_pkg::CntW;

  stte_pkg::state_t state_r, state_nxt;
  logic [31:0]  tmo_r;
  logic [216:0] req_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;  // search bounds, later scan indexes
  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] ev_r, ev_nxt;
  logic          ph_r, ph_nxt;                // 0: address issued, 1: data back
  logic [183:0]  out_r, out_nxt;
  logic          ov_r, ov_nxt;

  logic [1:0]  rq;
  logic [47:0] now;
  logic [31:0] key;
  assign rq  = req_r[1:0];
  assign now = req_r[49:2];
  assign key = req_r[81:50];

  logic [IW-1:0] raddr, waddr;
  logic          we;
  stte_pkg::entry_t wdata, rdata, newent;
  logic [CW-1:0] mid;
  logic [47:0]   age;

  stte_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign age = now - rdata.ref_at;

  always_comb begin
    newent.key     = key;
    newent.frame   = req_r[113:82];
    newent.box     = req_r[177:114];
    newent.kind    = req_r[180:178];
    newent.quality = req_r[212:181];
    newent.ins_at  = now;
    newent.ref_at  = now;
  end

  function automatic logic [183:0] pack_res(logic [2:0] st, logic [IW-1:0] sl,
                                            logic [CW-1:0] ec, logic [CW-1:0] ev,
                                            stte_pkg::entry_t e, logic show);
    logic [183:0] v;
    v = '0;
    v[2:0]  = st;
    v[6:3]  = 4'(sl);
    v[11:7] = 5'(ec);
    v[16:12] = 5'(ev);
    if (show) begin
      v[48:17]   = e.key;
      v[80:49]   = e.frame;
      v[144:81]  = e.box;
      v[147:145] = e.kind;
      v[179:148] = e.quality;
    end
    return v;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stte_pkg::S_IDLE: if (in_tvalid && in_tready) begin
        unique case (in_tdata[1:0])
          stte_pkg::ReqReport: state_nxt = stte_pkg::S_SEARCH;
          stte_pkg::ReqSweep:  state_nxt = stte_pkg::S_SWEEP;
          default:             state_nxt = stte_pkg::S_READ;
        endcase
      end
      stte_pkg::S_SEARCH: if (ph_r) begin
        if (rdata.key == key) state_nxt = stte_pkg::S_DONE;
        else if (rdata.key > key ? (mid == lo_r) : (mid + 1'b1 >= hi_r))
          state_nxt = (cnt_r >= CW'(stte_pkg::Capacity)) ? stte_pkg::S_DONE
                                                         : stte_pkg::S_SHIFT;
      end else if (lo_r >= hi_r) begin
        state_nxt = (cnt_r >= CW'(stte_pkg::Capacity)) ? stte_pkg::S_DONE
                                                       : stte_pkg::S_SHIFT;
      end
      stte_pkg::S_SHIFT: if (hi_r <= lo_r) state_nxt = stte_pkg::S_DONE;
      stte_pkg::S_SWEEP: if (!ph_r && hi_r >= cnt_r) state_nxt = stte_pkg::S_DONE;
      stte_pkg::S_READ:  if (ph_r) state_nxt = stte_pkg::S_DONE;
      stte_pkg::S_DONE:  if (!ov_r) state_nxt = stte_pkg::S_IDLE;
      default: state_nxt = stte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt = lo_r; hi_nxt = hi_r; kept_nxt = kept_r; ev_nxt = ev_r;
    ph_nxt = ph_r; cnt_nxt = cnt_r; out_nxt = out_r; ov_nxt = ov_r;
    we = 1'b0; waddr = lo_r[IW-1:0]; wdata = newent; raddr = mid[IW-1:0];
    // The result register is rewritten while a transaction is worked on, so a new
    // one is taken only once the previous result has left.
    in_tready = (state_r == stte_pkg::S_IDLE) && !ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      stte_pkg::S_IDLE: begin
        lo_nxt = '0; hi_nxt = cnt_r; kept_nxt = '0; ev_nxt = '0; ph_nxt = 1'b0;
        if (in_tvalid && in_tdata[1:0] == stte_pkg::ReqSweep) hi_nxt = '0;
      end
      stte_pkg::S_SEARCH: begin
        raddr = mid[IW-1:0];
        if (!ph_r) begin
          if (lo_r < hi_r) ph_nxt = 1'b1;
          else begin
            hi_nxt = cnt_r;  // shift walks from the top down to lo
          end
        end else begin
          ph_nxt = 1'b0;
          if (rdata.key == key) begin
            we = 1'b1; waddr = mid[IW-1:0];
            wdata = newent; wdata.key = rdata.key;
            wdata.ins_at = rdata.ins_at;
            out_nxt = pack_res(stte_pkg::StUpdated, mid[IW-1:0], cnt_r, '0, rdata, 1'b0);
          end else if (rdata.key > key) hi_nxt = mid;
          else lo_nxt = mid + 1'b1;
          if (rdata.key != key &&
              (rdata.key > key ? (mid == lo_r) : (mid + 1'b1 >= hi_r))) begin
            hi_nxt = cnt_r;
            if (rdata.key < key) lo_nxt = mid + 1'b1; else lo_nxt = lo_r;
          end
        end
        if (state_nxt == stte_pkg::S_DONE && rdata.key != key || (!ph_r &&
            state_nxt == stte_pkg::S_DONE))
          out_nxt = pack_res(stte_pkg::StFull, '0, cnt_r, '0, rdata, 1'b0);
      end
      stte_pkg::S_SHIFT: begin
        raddr = IW'(hi_r - 1'b1);
        if (hi_r <= lo_r) begin
          we = 1'b1; waddr = lo_r[IW-1:0]; wdata = newent;
          cnt_nxt = cnt_r + 1'b1;
          out_nxt = pack_res(stte_pkg::StInserted, lo_r[IW-1:0], cnt_r + 1'b1,
                             '0, rdata, 1'b0);
        end else if (!ph_r) ph_nxt = 1'b1;
        else begin
          ph_nxt = 1'b0;
          we = 1'b1; waddr = hi_r[IW-1:0]; wdata = rdata;
          hi_nxt = hi_r - 1'b1;
        end
      end
      stte_pkg::S_SWEEP: begin
        raddr = hi_r[IW-1:0];
        if (!ph_r) begin
          if (hi_r < cnt_r) ph_nxt = 1'b1;
          else begin
            cnt_nxt = kept_r;
            out_nxt = pack_res(stte_pkg::StSwept, '0, kept_r, ev_r, rdata, 1'b0);
          end
        end else begin
          ph_nxt = 1'b0;
          hi_nxt = hi_r + 1'b1;
          if (age > {16'd0, tmo_r}) ev_nxt = ev_r + 1'b1;
          else begin
            we = (kept_r != hi_r); waddr = kept_r[IW-1:0]; wdata = rdata;
            kept_nxt = kept_r + 1'b1;
          end
        end
      end
      stte_pkg::S_READ: begin
        raddr = req_r[216:213];
        ph_nxt = 1'b1;
        if (ph_r) begin
          if (rq == stte_pkg::ReqRead && {1'b0, req_r[216:213]} < cnt_r)
            out_nxt = pack_res(stte_pkg::StReadOk, req_r[216:213], cnt_r, '0,
                               rdata, 1'b1);
          else if (rq == stte_pkg::ReqRead)
            out_nxt = pack_res(stte_pkg::StBadIdx, req_r[216:213], cnt_r, '0,
                               rdata, 1'b0);
          else
            out_nxt = pack_res(stte_pkg::StBadIdx, '0, cnt_r, '0, rdata, 1'b0);
        end
      end
      stte_pkg::S_DONE: if (!ov_r) ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stte_pkg::S_IDLE;
      tmo_r   <= 32'd1000;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) tmo_r <= cfg_wdata;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) req_r <= in_tdata[216:0];
    lo_r <= lo_nxt; hi_r <= hi_nxt; kept_r <= kept_nxt; ev_r <= ev_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  `STT_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CW'(stte_pkg::Capacity))
  `STT_ASSERT_IMP(a_busy, state_r != stte_pkg::S_IDLE, !in_tready)
  `STT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
